FILE: rtl/tdgg_pkg.sv
// Shared types and constants of the teleop deadman and gripper gate.
// Holds the request and response layouts, the register map and reset values.
// Depends on nothing; every other file in rtl imports it.
`timescale 1ns / 1ps

package tdgg_pkg;

   // Widths of the stream and register ports.
   localparam int ReqDataW = 96;
   localparam int ReqUserW = 2;
   localparam int RspDataW = 48;
   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 16;

   // Widths of the fixed-point fields.
   localparam int LevelW   = 15;
   localparam int StickW   = 16;
   localparam int SpeedW   = 16;
   localparam int ChassisW = 18;

   // Register map.
   typedef enum logic [CsrIdxW-1:0] {
      CSR_REQUIRE_SAFETY    = 3'd0,
      CSR_DEADMAN_THRESHOLD = 3'd1,
      CSR_TOGGLE_HIGH       = 3'd2,
      CSR_TOGGLE_LOW        = 3'd3,
      CSR_BINARY_THRESHOLD  = 3'd4,
      CSR_MAX_LINEAR        = 3'd5,
      CSR_MAX_ANGULAR       = 3'd6
   } csr_index_type;

   // Reset values of the registers.
   localparam logic              RstRequireSafety   = 1'b1;
   localparam logic [LevelW-1:0] RstDeadmanThreshold = 15'd16384;
   localparam logic [LevelW-1:0] RstToggleHigh       = 15'd26214;
   localparam logic [LevelW-1:0] RstToggleLow        = 15'd6554;
   localparam logic [LevelW-1:0] RstBinaryThreshold  = 15'd16384;
   localparam logic [SpeedW-1:0] RstMaxLinear        = 16'd128;
   localparam logic [SpeedW-1:0] RstMaxAngular       = 16'd256;

   typedef struct packed {
      logic              require_safety;
      logic [LevelW-1:0] deadman_threshold;
      logic [LevelW-1:0] toggle_high;
      logic [LevelW-1:0] toggle_low;
      logic [LevelW-1:0] binary_threshold;
      logic [SpeedW-1:0] max_linear;
      logic [SpeedW-1:0] max_angular;
   } cfg_type;

   // Thresholds that one toggle latch needs.
   typedef struct packed {
      logic [LevelW-1:0] high;
      logic [LevelW-1:0] low;
      logic [LevelW-1:0] binary;
   } latch_cfg_type;

   // One teleop frame as held in the input register.
   typedef struct packed {
      logic                     axes_present;
      logic                     flags_valid;
      logic signed [StickW-1:0] stick_y;
      logic signed [StickW-1:0] stick_x;
      logic [LevelW-1:0]        left_trig;
      logic [LevelW-1:0]        right_trig;
      logic [LevelW-1:0]        left_grip_lvl;
      logic [LevelW-1:0]        right_grip_lvl;
      logic                     left_flag;
      logic                     right_flag;
      logic                     left_tracked;
      logic                     right_tracked;
   } frame_type;

   // One response; packed with the last field in the lowest bits.
   typedef struct packed {
      logic signed [ChassisW-1:0] chassis_angular;
      logic signed [ChassisW-1:0] chassis_linear;
      logic                       left_grip_close;
      logic                       right_grip_close;
      logic                       left_grip_ok;
      logic                       right_grip_ok;
      logic                       any_deadman;
      logic                       left_deadman_on;
      logic                       right_deadman_on;
      logic                       left_arm_ok;
      logic                       right_arm_ok;
   } result_type;

   localparam int ResultW = $bits(result_type);

endpackage

FILE: rtl/teleop_deadman_gripper_gate.sv
// Top level of the teleop deadman and gripper gate: stream ports, registers, two stages.
// Depends on tdgg_pkg, tdgg_latch and tdgg_drive.
`timescale 1ns / 1ps

// Each request is one teleop frame for both arms, and each frame yields exactly one
// response. The block takes one frame per clock cycle when the response side keeps up;
// a frame is held in the input register until the response register is free; its
// response is then captured in the response register and presented from there until
// it is taken. Arm validity follows tracking and, while require_safety is set, the
// frame's safety flags. With controller axes present, each grip value forms a deadman
// signal, each gripper's toggle latch steps once per frame while that gripper is
// valid, and the left deadman lets the left stick drive the chassis, scaled by the
// configured maximum speeds and floored to Q8.8. Without axes all deadman, gripper
// and chassis fields read zero and the latches keep their values. The user must write
// registers through the csr port only while no frame is in flight; the block itself
// does not enforce this.
module teleop_deadman_gripper_gate (
   input  logic                          clock,
   input  logic                          reset,
   // Request stream.
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // Fields from bit 0: right_tracked, left_tracked, right safety flag, left safety flag,
   // right grip, left grip, right trigger, left trigger, stick_x, stick_y.
   input  logic [tdgg_pkg::ReqDataW-1:0] req_tdata,
   // Fields from bit 0: safety flags present, axes_present.
   input  logic [tdgg_pkg::ReqUserW-1:0] req_tuser,
   // Response stream.
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // Fields from bit 0: right_arm_ok, left_arm_ok, right_deadman_on, left_deadman_on,
   // any_deadman, right_grip_ok, left_grip_ok, right_grip_close, left_grip_close,
   // chassis_linear, chassis_angular, then zero padding.
   output logic [tdgg_pkg::RspDataW-1:0] rsp_tdata,
   // Register write port.
   input  logic                          csr_we,
   input  logic [tdgg_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [tdgg_pkg::CsrDataW-1:0] csr_wdata
);
   import tdgg_pkg::*;

   cfg_type       cfg_ff;
   frame_type     frame_ff;
   logic          frame_valid_ff;
   result_type    rsp_ff;
   result_type    rsp_in;
   logic          rsp_valid_ff;
   logic          rsp_open;
   logic          frame_fire;
   latch_cfg_type latch_cfg;

   logic          right_ok;
   logic          left_ok;
   logic          right_dm;
   logic          left_dm;
   logic          right_gok;
   logic          left_gok;
   logic          right_close;
   logic          left_close;
   logic signed [ChassisW-1:0] linear;
   logic signed [ChassisW-1:0] angular;

   // The response register frees itself when it is empty or being taken, so a new
   // request is accepted even while a finished response still waits.
   assign rsp_open   = !rsp_valid_ff || rsp_tready;
   assign frame_fire = frame_valid_ff && rsp_open;
   assign req_tready = !frame_valid_ff || rsp_open;

   // Register file. Writes to an index beyond the map are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.require_safety    <= RstRequireSafety;
         cfg_ff.deadman_threshold <= RstDeadmanThreshold;
         cfg_ff.toggle_high       <= RstToggleHigh;
         cfg_ff.toggle_low        <= RstToggleLow;
         cfg_ff.binary_threshold  <= RstBinaryThreshold;
         cfg_ff.max_linear        <= RstMaxLinear;
         cfg_ff.max_angular       <= RstMaxAngular;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_REQUIRE_SAFETY:    cfg_ff.require_safety    <= csr_wdata[0];
            CSR_DEADMAN_THRESHOLD: cfg_ff.deadman_threshold <= csr_wdata[LevelW-1:0];
            CSR_TOGGLE_HIGH:       cfg_ff.toggle_high       <= csr_wdata[LevelW-1:0];
            CSR_TOGGLE_LOW:        cfg_ff.toggle_low        <= csr_wdata[LevelW-1:0];
            CSR_BINARY_THRESHOLD:  cfg_ff.binary_threshold  <= csr_wdata[LevelW-1:0];
            CSR_MAX_LINEAR:        cfg_ff.max_linear        <= csr_wdata[SpeedW-1:0];
            CSR_MAX_ANGULAR:       cfg_ff.max_angular       <= csr_wdata[SpeedW-1:0];
            default: ;
         endcase
      end
   end

   // Input register: the frame is unpacked from the stream as it is captured.
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_valid_ff <= 1'b0;
      end else if (req_tready) begin
         frame_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         frame_ff.right_tracked  <= req_tdata[0];
         frame_ff.left_tracked   <= req_tdata[1];
         frame_ff.right_flag     <= req_tdata[2];
         frame_ff.left_flag      <= req_tdata[3];
         frame_ff.right_grip_lvl <= req_tdata[18:4];
         frame_ff.left_grip_lvl  <= req_tdata[33:19];
         frame_ff.right_trig     <= req_tdata[48:34];
         frame_ff.left_trig      <= req_tdata[63:49];
         frame_ff.stick_x        <= req_tdata[79:64];
         frame_ff.stick_y        <= req_tdata[95:80];
         frame_ff.flags_valid    <= req_tuser[0];
         frame_ff.axes_present   <= req_tuser[1];
      end
   end

   // Validity and deadman gating.
   always_comb begin
      right_ok  = frame_ff.right_tracked && (!cfg_ff.require_safety
                  || (frame_ff.flags_valid && frame_ff.right_flag));
      left_ok   = frame_ff.left_tracked && (!cfg_ff.require_safety
                  || (frame_ff.flags_valid && frame_ff.left_flag));
      right_dm  = frame_ff.axes_present && right_ok
                  && (frame_ff.right_grip_lvl >= cfg_ff.deadman_threshold);
      left_dm   = frame_ff.axes_present && left_ok
                  && (frame_ff.left_grip_lvl >= cfg_ff.deadman_threshold);
      right_gok = frame_ff.axes_present && (!cfg_ff.require_safety || right_dm);
      left_gok  = frame_ff.axes_present && (!cfg_ff.require_safety || left_dm);
   end

   assign latch_cfg.high   = cfg_ff.toggle_high;
   assign latch_cfg.low    = cfg_ff.toggle_low;
   assign latch_cfg.binary = cfg_ff.binary_threshold;

   // Each latch steps only when its frame moves on to the response register.
   tdgg_latch u_right_latch (
      .clock      (clock),
      .reset      (reset),
      .advance    (frame_fire && right_gok),
      .trigger    (frame_ff.right_trig),
      .thresholds (latch_cfg),
      .close      (right_close)
   );

   tdgg_latch u_left_latch (
      .clock      (clock),
      .reset      (reset),
      .advance    (frame_fire && left_gok),
      .trigger    (frame_ff.left_trig),
      .thresholds (latch_cfg),
      .close      (left_close)
   );

   tdgg_drive u_drive (
      .enable      (left_dm),
      .stick_x     (frame_ff.stick_x),
      .stick_y     (frame_ff.stick_y),
      .max_linear  (cfg_ff.max_linear),
      .max_angular (cfg_ff.max_angular),
      .linear      (linear),
      .angular     (angular)
   );

   always_comb begin
      rsp_in.right_arm_ok     = right_ok;
      rsp_in.left_arm_ok      = left_ok;
      rsp_in.right_deadman_on = right_dm;
      rsp_in.left_deadman_on  = left_dm;
      rsp_in.any_deadman      = right_dm || left_dm;
      rsp_in.right_grip_ok    = right_gok;
      rsp_in.left_grip_ok     = left_gok;
      rsp_in.right_grip_close = right_gok && right_close;
      rsp_in.left_grip_close  = left_gok && left_close;
      rsp_in.chassis_linear   = linear;
      rsp_in.chassis_angular  = angular;
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_open) begin
         rsp_valid_ff <= frame_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (frame_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RspDataW - ResultW){1'b0}}, rsp_ff};

`ifndef SYNTHESIS
   a_chassis_needs_left_deadman: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_ff.left_deadman_on
      |-> (rsp_ff.chassis_linear == '0) && (rsp_ff.chassis_angular == '0))
      else $error("chassis driven without the left deadman");

   a_close_needs_grip_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (!rsp_ff.right_grip_close || rsp_ff.right_grip_ok)
                     && (!rsp_ff.left_grip_close || rsp_ff.left_grip_ok))
      else $error("gripper close on an invalid gripper");

   a_deadman_needs_arm: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (!rsp_ff.right_deadman_on || rsp_ff.right_arm_ok)
                     && (!rsp_ff.left_deadman_on || rsp_ff.left_arm_ok))
      else $error("deadman engaged on an invalid arm");

   a_held_response_kept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("response register overwritten while stalled");
`endif

endmodule

FILE: rtl/tdgg_latch.sv
// Two-bit toggle latch for one gripper: arms on a high trigger, flips hold on release.
// Depends on tdgg_pkg for the threshold bundle.
`timescale 1ns / 1ps

module tdgg_latch (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic [tdgg_pkg::LevelW-1:0] trigger,
   input  tdgg_pkg::latch_cfg_type     thresholds,
   output logic                        close
);
   import tdgg_pkg::*;

   logic hold_ff;
   logic hold_in;
   logic armed_ff;
   logic armed_in;

   always_comb begin
      hold_in  = hold_ff;
      armed_in = armed_ff;
      if (trigger > thresholds.high) begin
         armed_in = 1'b1;
      end else if (armed_ff && (trigger < thresholds.low)) begin
         hold_in  = ~hold_ff;
         armed_in = 1'b0;
      end
   end

   // The close command sees the hold value after this frame's step.
   assign close = hold_in || (trigger > thresholds.binary);

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff  <= 1'b0;
         armed_ff <= 1'b0;
      end else if (advance) begin
         hold_ff  <= hold_in;
         armed_ff <= armed_in;
      end
   end

`ifndef SYNTHESIS
   a_frozen_when_idle: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(hold_ff) && $stable(armed_ff))
      else $error("gripper latch moved without a frame");

   a_hold_flips_on_release: assert property (@(posedge clock) disable iff (reset)
      !reset |=> (hold_ff == $past(hold_ff)) || ($past(armed_ff) && !armed_ff))
      else $error("hold flipped without an armed latch being released");

   a_arms_on_high_trigger: assert property (@(posedge clock) disable iff (reset)
      advance && (trigger > thresholds.high) |=> armed_ff)
      else $error("gripper latch failed to arm on a high trigger");
`endif

endmodule

FILE: rtl/tdgg_drive.sv
// Chassis drive products: stick times maximum speed, Q8.8, floored.
// Depends on tdgg_pkg for field widths.
`timescale 1ns / 1ps

module tdgg_drive (
   input  logic                                enable,
   input  logic signed [tdgg_pkg::StickW-1:0]  stick_x,
   input  logic signed [tdgg_pkg::StickW-1:0]  stick_y,
   input  logic [tdgg_pkg::SpeedW-1:0]         max_linear,
   input  logic [tdgg_pkg::SpeedW-1:0]         max_angular,
   output logic signed [tdgg_pkg::ChassisW-1:0] linear,
   output logic signed [tdgg_pkg::ChassisW-1:0] angular
);
   import tdgg_pkg::*;

   localparam int OpW   = StickW + 1;
   localparam int ProdW = 2 * OpW;
   localparam int Frac  = StickW - 1;

   logic signed [OpW-1:0]   y_ext;
   logic signed [OpW-1:0]   x_neg;
   logic signed [OpW-1:0]   lin_speed;
   logic signed [OpW-1:0]   ang_speed;
   logic signed [ProdW-1:0] lin_prod;
   logic signed [ProdW-1:0] ang_prod;

   // One extra bit lets the negated full-scale stick read +1.0.
   assign y_ext     = {stick_y[StickW-1], stick_y};
   assign x_neg     = -{stick_x[StickW-1], stick_x};
   assign lin_speed = {1'b0, max_linear};
   assign ang_speed = {1'b0, max_angular};
   assign lin_prod  = y_ext * lin_speed;
   assign ang_prod  = x_neg * ang_speed;

   // Dropping the fraction bits of a two's complement product floors it.
   assign linear  = enable ? lin_prod[Frac+ChassisW-1:Frac] : '0;
   assign angular = enable ? ang_prod[Frac+ChassisW-1:Frac] : '0;

endmodule

FILE: sim/tb.sv
// Self-checking testbench for the teleop deadman and gripper gate.
// Drives random and directed frames with random flow control and checks every response.
// Depends on tdgg_pkg and teleop_deadman_gripper_gate from the rtl folder.
`timescale 1ns / 1ps

module tb;

   import tdgg_pkg::*;

   // Toggle latch slots in the model: one per gripper.
   localparam int RightSide = 0;
   localparam int LeftSide  = 1;

   // A register index past the end of the map; writes to it must be ignored.
   localparam logic [CsrIdxW-1:0] CsrUnmapped = 3'd7;

   localparam logic [LevelW-1:0] LevelMax = 15'h7fff;
   localparam logic signed [StickW-1:0] StickMin = 16'sh8000;
   localparam logic signed [StickW-1:0] StickMax = 16'sh7fff;

   // One teleop frame as the testbench sees it, before packing onto the bus.
   typedef struct {
      logic                     right_tracked;
      logic                     left_tracked;
      logic                     flags_valid;
      logic                     right_flag;
      logic                     left_flag;
      logic                     axes_present;
      logic [LevelW-1:0]        right_grip_lvl;
      logic [LevelW-1:0]        left_grip_lvl;
      logic [LevelW-1:0]        right_trig;
      logic [LevelW-1:0]        left_trig;
      logic signed [StickW-1:0] stick_x;
      logic signed [StickW-1:0] stick_y;
   } teleop_frame_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [ReqDataW-1:0] req_tdata = '0;
   logic [ReqUserW-1:0] req_tuser = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RspDataW-1:0] rsp_tdata;
   logic                csr_we = 1'b0;
   logic [CsrIdxW-1:0]  csr_index = '0;
   logic [CsrDataW-1:0] csr_wdata = '0;

   // The model's copy of the registers, starting from the reset values.
   logic              cfg_require_safety    = RstRequireSafety;
   logic [LevelW-1:0] cfg_deadman_threshold = RstDeadmanThreshold;
   logic [LevelW-1:0] cfg_toggle_high       = RstToggleHigh;
   logic [LevelW-1:0] cfg_toggle_low        = RstToggleLow;
   logic [LevelW-1:0] cfg_binary_threshold  = RstBinaryThreshold;
   logic [SpeedW-1:0] cfg_max_linear        = RstMaxLinear;
   logic [SpeedW-1:0] cfg_max_angular       = RstMaxAngular;

   // The model's toggle latches, indexed by side.
   logic toggle_hold [2]  = '{1'b0, 1'b0};
   logic toggle_armed [2] = '{1'b0, 1'b0};

   teleop_frame_type frames_pending [$];   // requests not yet offered to the block
   teleop_frame_type frame_on_bus;         // the request currently offered
   result_type       outputs_due [$];      // predicted responses, oldest first

   int requests_queued   = 0;
   int requests_accepted = 0;
   int responses_seen    = 0;
   int mismatch_count    = 0;

   // Idle rates in percent; the stimulus process changes them between phases.
   int  sender_idle_pct   = 35;
   int  receiver_idle_pct = 59;
   logic rsp_hold = 1'b0;

   teleop_deadman_gripper_gate dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Model of the block
   // ------------------------------------------------------------------

   // One step of a gripper's toggle latch. The latch arms on a trigger above the
   // high level; an armed latch flips hold and disarms on a trigger below the low
   // level. The gripper closes while hold is set or the trigger is above the
   // binary level.
   function automatic logic step_toggle(input int side, input logic [LevelW-1:0] trig);
      if (trig > cfg_toggle_high) begin
         toggle_armed[side] = 1'b1;
      end else if (toggle_armed[side] && trig < cfg_toggle_low) begin
         toggle_hold[side]  = !toggle_hold[side];
         toggle_armed[side] = 1'b0;
      end
      return toggle_hold[side] || trig > cfg_binary_threshold;
   endfunction

   // Works out the response to one accepted request and queues it. Without axes
   // every deadman, gripper and chassis field stays at zero and no latch moves.
   task automatic predict_gate_outputs(input teleop_frame_type f);
      result_type  r;
      logic        need_safety;
      longint      lin_q;
      longint      ang_q;
      need_safety = cfg_require_safety;
      r = '0;
      r.right_arm_ok = f.right_tracked &&
                       (!need_safety || (f.flags_valid && f.right_flag));
      r.left_arm_ok  = f.left_tracked &&
                       (!need_safety || (f.flags_valid && f.left_flag));
      if (f.axes_present) begin
         r.right_deadman_on = r.right_arm_ok && f.right_grip_lvl >= cfg_deadman_threshold;
         r.left_deadman_on  = r.left_arm_ok && f.left_grip_lvl >= cfg_deadman_threshold;
         r.any_deadman      = r.right_deadman_on || r.left_deadman_on;
         // With safety not required a gripper is valid even on an untracked arm.
         r.right_grip_ok    = !need_safety || r.right_deadman_on;
         r.left_grip_ok     = !need_safety || r.left_deadman_on;
         if (r.right_grip_ok) begin
            r.right_grip_close = step_toggle(RightSide, f.right_trig);
         end
         if (r.left_grip_ok) begin
            r.left_grip_close = step_toggle(LeftSide, f.left_trig);
         end
         // Only the left deadman lets the stick drive the chassis. The products
         // are floored by an arithmetic shift; a full-scale negative x negates
         // to +32768 since the arithmetic is worked out in 64 bits.
         if (r.left_deadman_on) begin
            lin_q = (longint'(f.stick_y) * longint'(cfg_max_linear)) >>> 15;
            ang_q = ((-longint'(f.stick_x)) * longint'(cfg_max_angular)) >>> 15;
            r.chassis_linear  = lin_q[ChassisW-1:0];
            r.chassis_angular = ang_q[ChassisW-1:0];
         end
      end
      outputs_due.push_back(r);
   endtask

   // ------------------------------------------------------------------
   // Request driver
   // ------------------------------------------------------------------

   function automatic logic [ReqDataW-1:0] pack_request(input teleop_frame_type f);
      return {f.stick_y, f.stick_x, f.left_trig, f.right_trig, f.left_grip_lvl,
              f.right_grip_lvl, f.left_flag, f.right_flag, f.left_tracked,
              f.right_tracked};
   endfunction

   // A request is predicted at the edge where it is accepted, so the model sees
   // requests in exactly the order the block takes them. A new request is only
   // put up once the previous one has gone, and tvalid gets a single assignment.
   always @(posedge clock) begin : drive_requests
      logic offer;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_gate_outputs(frame_on_bus);
            requests_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            offer = frames_pending.size() != 0 &&
                    $urandom_range(99, 0) >= sender_idle_pct;
            if (offer) begin
               frame_on_bus = frames_pending.pop_front();
               req_tdata <= pack_request(frame_on_bus);
               req_tuser <= {frame_on_bus.axes_present, frame_on_bus.flags_valid};
            end
            req_tvalid <= offer;
         end
      end
   end

   // ------------------------------------------------------------------
   // Response monitor and checker
   // ------------------------------------------------------------------

   task automatic check_field(input string field, input logic [ChassisW-1:0] want,
                              input logic [ChassisW-1:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= 10) begin
            $display("response %0d: %s expected %h, got %h",
                     responses_seen, field, want, got);
         end
      end
   endtask

   always @(posedge clock) begin : check_responses
      result_type got;
      result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[ResultW-1:0];
            responses_seen++;
            if (outputs_due.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("response %0d arrived with no request outstanding: %h",
                           responses_seen, rsp_tdata);
               end
            end else begin
               want = outputs_due.pop_front();
               check_field("right_arm_ok", want.right_arm_ok, got.right_arm_ok);
               check_field("left_arm_ok", want.left_arm_ok, got.left_arm_ok);
               check_field("right_deadman_on", want.right_deadman_on, got.right_deadman_on);
               check_field("left_deadman_on", want.left_deadman_on, got.left_deadman_on);
               check_field("any_deadman", want.any_deadman, got.any_deadman);
               check_field("right_grip_ok", want.right_grip_ok, got.right_grip_ok);
               check_field("left_grip_ok", want.left_grip_ok, got.left_grip_ok);
               check_field("right_grip_close", want.right_grip_close, got.right_grip_close);
               check_field("left_grip_close", want.left_grip_close, got.left_grip_close);
               check_field("chassis_linear", want.chassis_linear, got.chassis_linear);
               check_field("chassis_angular", want.chassis_angular, got.chassis_angular);
               check_field("padding", '0, rsp_tdata[RspDataW-1:ResultW]);
            end
         end
         rsp_tready <= !rsp_hold && $urandom_range(99, 0) >= receiver_idle_pct;
      end
   end

   // Once the run is well under way the receiver refuses responses for a long
   // stretch, so that the block fills and has to push back on its requests.
   initial begin : long_response_stall
      while (requests_accepted < 900) @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (300) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   function automatic logic chance(input int pct);
      return $urandom_range(99, 0) < pct;
   endfunction

   function automatic logic [LevelW-1:0] level_at(input int v);
      if (v < 0) return '0;
      if (v > int'(LevelMax)) return LevelMax;
      return v[LevelW-1:0];
   endfunction

   function automatic teleop_frame_type make_frame(
         input logic rt, input logic lt, input logic sp, input logic sr,
         input logic sl, input logic ax,
         input logic [LevelW-1:0] gr, input logic [LevelW-1:0] gl,
         input logic [LevelW-1:0] tr, input logic [LevelW-1:0] tl,
         input logic signed [StickW-1:0] sx, input logic signed [StickW-1:0] sy);
      teleop_frame_type f;
      f.right_tracked  = rt;
      f.left_tracked   = lt;
      f.flags_valid    = sp;
      f.right_flag     = sr;
      f.left_flag      = sl;
      f.axes_present   = ax;
      f.right_grip_lvl = gr;
      f.left_grip_lvl  = gl;
      f.right_trig     = tr;
      f.left_trig      = tl;
      f.stick_x        = sx;
      f.stick_y        = sy;
      return f;
   endfunction

   // Grip values sit mostly at or above the deadman level so that the grippers
   // stay valid long enough for the latches to work through their sequences.
   function automatic logic [LevelW-1:0] pick_grip();
      int thr;
      thr = cfg_deadman_threshold;
      case ($urandom_range(5, 0))
         0: return level_at(thr);
         1: return level_at(thr - 1);
         2: return level_at($urandom_range(32767, 0));
         default: return level_at($urandom_range(32767, thr));
      endcase
   endfunction

   // Triggers are drawn around the arming, toggling and binary levels.
   function automatic logic [LevelW-1:0] pick_trigger();
      int hi;
      int lo;
      hi = cfg_toggle_high;
      lo = cfg_toggle_low;
      case ($urandom_range(7, 0))
         0, 1: return level_at($urandom_range(32767, hi + 1));
         2, 3: return (lo == 0) ? '0 : level_at($urandom_range(lo - 1, 0));
         4: return level_at(chance(50) ? hi : lo);
         5: return level_at(int'(cfg_binary_threshold) + $urandom_range(1, 0));
         default: return level_at($urandom_range(32767, 0));
      endcase
   endfunction

   function automatic logic signed [StickW-1:0] pick_stick();
      if (chance(85)) return StickW'($urandom);
      case ($urandom_range(3, 0))
         0: return StickMin;
         1: return StickMax;
         2: return '0;
         default: return '1;
      endcase
   endfunction

   // Most frames are well formed and engage both arms; the rest are pure noise.
   function automatic teleop_frame_type random_frame();
      if (chance(15)) begin
         return make_frame(chance(50), chance(50), chance(50), chance(50),
                           chance(50), chance(50), LevelW'($urandom), LevelW'($urandom),
                           LevelW'($urandom), LevelW'($urandom), StickW'($urandom),
                           StickW'($urandom));
      end
      return make_frame(chance(92), chance(92), chance(92), chance(92), chance(92),
                        chance(92), pick_grip(), pick_grip(), pick_trigger(),
                        pick_trigger(), pick_stick(), pick_stick());
   endfunction

   task automatic queue_frame(input teleop_frame_type f);
      frames_pending.push_back(f);
      requests_queued++;
   endtask

   // Waits until every queued request has been answered, then lets the pipeline
   // settle before any register is touched.
   task automatic drain();
      while (responses_seen < requests_queued) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CsrIdxW-1:0] idx,
                            input logic [CsrDataW-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_REQUIRE_SAFETY:    cfg_require_safety    = value[0];
         CSR_DEADMAN_THRESHOLD: cfg_deadman_threshold = value[LevelW-1:0];
         CSR_TOGGLE_HIGH:       cfg_toggle_high       = value[LevelW-1:0];
         CSR_TOGGLE_LOW:        cfg_toggle_low        = value[LevelW-1:0];
         CSR_BINARY_THRESHOLD:  cfg_binary_threshold  = value[LevelW-1:0];
         CSR_MAX_LINEAR:        cfg_max_linear        = value;
         CSR_MAX_ANGULAR:       cfg_max_angular       = value;
         default: ;
      endcase
   endtask

   task automatic apply_settings(input logic rs, input int dm, input int th, input int tl,
                                 input int bt, input int ml, input int ma);
      write_csr(CSR_REQUIRE_SAFETY, CsrDataW'(rs));
      write_csr(CSR_DEADMAN_THRESHOLD, CsrDataW'(dm));
      write_csr(CSR_TOGGLE_HIGH, CsrDataW'(th));
      write_csr(CSR_TOGGLE_LOW, CsrDataW'(tl));
      write_csr(CSR_BINARY_THRESHOLD, CsrDataW'(bt));
      write_csr(CSR_MAX_LINEAR, CsrDataW'(ml));
      write_csr(CSR_MAX_ANGULAR, CsrDataW'(ma));
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------

   initial begin : stimulus
      int phase;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // A write past the register map must leave every register alone.
      write_csr(CsrUnmapped, '1);
      @(posedge clock);
      csr_we <= 1'b0;

      // Directed frames under the reset settings. The trigger runs walk both
      // latches through arming, the exact levels, toggling on and toggling off.
      queue_frame(make_frame(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      // Without axes nothing but arm validity is reported, and no latch moves.
      queue_frame(make_frame(1, 1, 1, 1, 1, 0, LevelMax, LevelMax, LevelMax, LevelMax,
                             StickMin, StickMax));
      // Grips exactly at the deadman level, full negative stick.
      queue_frame(make_frame(1, 1, 1, 1, 1, 1, 16384, 16384, 0, 0, StickMin, StickMin));
      queue_frame(make_frame(1, 1, 1, 1, 1, 1, 16383, 16383, 0, 0, StickMax, StickMax));
      queue_frame(make_frame(1, 1, 1, 1, 1, 1, LevelMax, LevelMax, 26215, 26215,
                             StickMax, StickMax));
      queue_frame(make_frame(1, 1, 1, 1, 1, 1, LevelMax, LevelMax, 26214, 26214, 100, -100));
      queue_frame(make_frame(1, 1, 1, 1, 1, 1, LevelMax, LevelMax, 6554, 6554, -1, 1));
      queue_frame(make_frame(1, 1, 1, 1, 1, 1, LevelMax, LevelMax, 6553, 6553, 1, -1));
      queue_frame(make_frame(1, 1, 1, 1, 1, 1, LevelMax, LevelMax, 0, 0, 0, 0));
      // One gripper invalid at a time: its latch must hold still and read open.
      queue_frame(make_frame(1, 1, 1, 1, 1, 1, 0, LevelMax, LevelMax, LevelMax,
                             12345, -12345));
      queue_frame(make_frame(1, 1, 1, 1, 1, 1, LevelMax, 0, LevelMax, LevelMax,
                             12345, -12345));
      queue_frame(make_frame(1, 1, 1, 1, 1, 1, LevelMax, LevelMax, 0, 0, -7, 7));
      queue_frame(make_frame(1, 1, 1, 1, 1, 0, LevelMax, LevelMax, LevelMax, LevelMax, 5, 5));
      // Missing safety flags, a single missing flag, an untracked arm.
      queue_frame(make_frame(1, 1, 0, 1, 1, 1, LevelMax, LevelMax, 0, 0, 5, 5));
      queue_frame(make_frame(1, 1, 1, 0, 1, 1, LevelMax, LevelMax, 0, 0, 5, 5));
      queue_frame(make_frame(0, 1, 1, 1, 1, 1, LevelMax, LevelMax, 0, 0, 5, 5));
      // The binary level itself does not close the gripper; one step above does.
      queue_frame(make_frame(1, 1, 1, 1, 1, 1, LevelMax, LevelMax, 16384, 16384, 0, 0));
      queue_frame(make_frame(1, 1, 1, 1, 1, 1, LevelMax, LevelMax, 16385, 16385, 0, 0));
      queue_frame(make_frame(1, 1, 1, 1, 1, 1, LevelMax, LevelMax, 0, 0, StickMin, StickMax));
      drain();

      // With safety not required, grippers follow the axes alone.
      apply_settings(1'b0, RstDeadmanThreshold, RstToggleHigh, RstToggleLow,
                     RstBinaryThreshold, RstMaxLinear, RstMaxAngular);
      queue_frame(make_frame(0, 0, 0, 0, 0, 1, 0, 0, LevelMax, LevelMax, 9, 9));
      queue_frame(make_frame(0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 9, 9));
      queue_frame(make_frame(1, 1, 0, 0, 0, 0, LevelMax, LevelMax, 0, 0, 9, 9));
      queue_frame(make_frame(1, 1, 0, 0, 0, 1, LevelMax, LevelMax, 0, 0, StickMin, StickMin));
      drain();

      // Random phases: two at the extremes of every register, the rest drawn at
      // random. Idling moves from a slow receiver, to a slow sender, to none.
      for (phase = 0; phase < 6; phase++) begin
         if (phase == 2) begin
            sender_idle_pct   = 59;
            receiver_idle_pct = 35;
         end else if (phase == 4) begin
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
         end
         if (phase == 0) begin
            apply_settings(1'b1, 0, 0, 0, 0, 65535, 65535);
         end else if (phase == 1) begin
            apply_settings(1'b0, 32767, 32767, 32767, 32767, 0, 0);
         end else begin
            apply_settings(chance(60), $urandom_range(32767, 0),
                           $urandom_range(32767, 16384), $urandom_range(16383, 0),
                           $urandom_range(32767, 0), $urandom_range(65535, 0),
                           $urandom_range(65535, 0));
         end
         repeat (250) queue_frame(random_frame());
         drain();
      end

      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && outputs_due.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin : watchdog
      #3000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
